@@ rtl/core/fcr_pkg.sv @@
// package: constants, packet type and crc helper for the framed command receiver
`default_nettype none
package fcr_pkg;

  // queue depth, 1..7 (queued_count is 3 bits wide)
  localparam int QUEUE_DEPTH = 4;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W  = 2;
  localparam int POS_W = 4;
  localparam int CFG_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_BYTE     = 2'd0;
  localparam logic [OP_W-1:0] OP_LINK_ERR = 2'd1;
  localparam logic [OP_W-1:0] OP_POP      = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_OVERWRITE = 3'd2;
  localparam logic [2:0] ST_CRC_ERR   = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  // register indexes
  localparam logic [CFG_W-1:0] CFG_AUTO       = 3'd0;
  localparam logic [CFG_W-1:0] CFG_MANUAL_POS = 3'd1;
  localparam logic [CFG_W-1:0] CFG_MANUAL_RATE = 3'd2;
  localparam logic [CFG_W-1:0] CFG_STOP       = 3'd3;
  localparam logic [CFG_W-1:0] CFG_HOME       = 3'd4;

  localparam logic [7:0] HDR_G = 8'h47;
  localparam logic [7:0] HDR_C = 8'h43;

  localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd2;
  localparam logic [POS_W-1:0] POS_SEQ_HI     = 4'd3;
  localparam logic [POS_W-1:0] POS_TYPE       = 4'd4;
  localparam logic [POS_W-1:0] POS_VAL_LO     = 4'd5;
  localparam logic [POS_W-1:0] POS_VAL_HI     = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC_LO     = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST       = 4'd8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic signed [15:0] POS_MAX  = 16'sd3599;
  localparam logic signed [15:0] RATE_MIN = -16'sd1000;
  localparam logic signed [15:0] RATE_MAX = 16'sd1000;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  ptype;
    logic [15:0] value;
  } pkt_t;

  typedef struct packed {
    logic [7:0] code_auto;
    logic [7:0] code_manual_position;
    logic [7:0] code_manual_rate;
    logic [7:0] code_stop;
    logic [7:0] code_home;
  } cfg_t;

  // crc-16 ccitt, one byte msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc after the two header bytes
  localparam logic [15:0] CRC_HDR = crc_byte(crc_byte(CRC_INIT, HDR_G), HDR_C);

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    if (p == QW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QW'(1);
  endfunction

  // type and value range check, first matching code wins
  function automatic logic value_ok(input cfg_t cfg, input logic [7:0] t,
                                    input logic signed [15:0] v);
    if (t == cfg.code_auto || t == cfg.code_manual_position) begin
      return (v >= 16'sd0) && (v <= POS_MAX);
    end
    if (t == cfg.code_manual_rate) begin
      return (v >= RATE_MIN) && (v <= RATE_MAX);
    end
    if (t == cfg.code_stop || t == cfg.code_home) begin
      return v == 16'sd0;
    end
    return 1'b0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/framed_command_receiver.sv @@
// top level: header hunt, frame collection, crc check and packet ring queue
`default_nettype none
// Takes one item per clock cycle while not stalled: a received byte, a link error
// or a pop. Each item gives exactly one result, held in an output register loaded
// at its transfer; a new item is taken in the same cycle the held result is taken.
// The header hunt, byte position and running crc are registers updated once per
// byte with a byte-wide crc step. Packets live in a single-port queue memory of
// fcr_pkg::QUEUE_DEPTH entries with registered read: a pop reads the head entry
// at its transfer edge and the data appears with the result. A completed valid
// frame writes at the tail and overwrites the oldest packet when the queue is
// full. Configuration writes are always taken (cfg_ready stays high) and are
// meant to happen only while no item is in flight.
module framed_command_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fcr_pkg::OP_W-1:0]    operation,
  input  logic [7:0]                  rx_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  frame_status,
  output logic                        pop_valid,
  output logic [15:0]                 popped_seq,
  output logic [7:0]                  popped_type,
  output logic signed [15:0]          popped_value,
  output logic [2:0]                  queued_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fcr_pkg::CFG_W-1:0]   cfg_index,
  input  logic [7:0]                  cfg_data
);
  import fcr_pkg::*;

  localparam logic [1:0] WAIT_G  = 2'd0;
  localparam logic [1:0] WAIT_C  = 2'd1;
  localparam logic [1:0] COLLECT = 2'd2;

  cfg_t cfg;

  logic [1:0]       hunt, hunt_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      crc, crc_next;
  logic [15:0]      seq, seq_next;
  logic [7:0]       ptype, ptype_next;
  logic [15:0]      pvalue, pvalue_next;
  logic [7:0]       crc_lo, crc_lo_next;
  logic [QW-1:0]    head, head_next;
  logic [QW-1:0]    tail, tail_next;
  logic [FW-1:0]    fill, fill_next;
  logic [2:0]       status_next;
  logic             pv_next;
  logic             wr_en;
  logic             accept;
  logic             do_pop;
  logic [15:0]      crc_upd;

  pkt_t queue_mem [QUEUE_DEPTH];
  pkt_t rd_pkt;
  pkt_t wr_pkt;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign crc_upd   = crc_byte(crc, rx_data);
  assign do_pop    = (operation == OP_POP) && (fill != '0);
  assign wr_pkt    = '{seq: seq, ptype: ptype, value: pvalue};

  always_comb begin
    hunt_next   = hunt;
    pos_next    = pos;
    crc_next    = crc;
    seq_next    = seq;
    ptype_next  = ptype;
    pvalue_next = pvalue;
    crc_lo_next = crc_lo;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    status_next = ST_NONE;
    pv_next     = 1'b0;
    wr_en       = 1'b0;
    case (operation)
      OP_BYTE: begin
        case (hunt)
          WAIT_G: begin
            if (rx_data == HDR_G) begin
              hunt_next = WAIT_C;
            end
          end
          WAIT_C: begin
            if (rx_data == HDR_C) begin
              crc_next  = CRC_HDR;
              pos_next  = POS_FIRST_DATA;
              hunt_next = COLLECT;
            end else if (rx_data != HDR_G) begin
              hunt_next = WAIT_G;
            end
          end
          COLLECT: begin
            if (pos >= POS_LAST) begin
              // last trailer byte completes the frame
              if ({rx_data, crc_lo} != crc) begin
                status_next = ST_CRC_ERR;
              end else if (!value_ok(cfg, ptype, signed'(pvalue))) begin
                status_next = ST_INVALID;
              end else begin
                wr_en     = 1'b1;
                tail_next = ptr_inc(tail);
                if (fill == FW'(QUEUE_DEPTH)) begin
                  head_next   = ptr_inc(tail);
                  status_next = ST_OVERWRITE;
                end else begin
                  fill_next   = fill + FW'(1);
                  status_next = ST_QUEUED;
                end
              end
              hunt_next = (rx_data == HDR_G) ? WAIT_C : WAIT_G;
              pos_next  = '0;
              crc_next  = CRC_INIT;
            end else begin
              case (pos)
                POS_FIRST_DATA: seq_next[7:0]    = rx_data;
                POS_SEQ_HI:     seq_next[15:8]   = rx_data;
                POS_TYPE:       ptype_next       = rx_data;
                POS_VAL_LO:     pvalue_next[7:0] = rx_data;
                POS_VAL_HI:     pvalue_next[15:8] = rx_data;
                POS_CRC_LO:     crc_lo_next      = rx_data;
                default: begin
                end
              endcase
              if (pos < POS_CRC_LO) begin
                crc_next = crc_upd;
              end
              pos_next = pos + POS_W'(1);
            end
          end
          default: begin
            hunt_next = WAIT_G;
            pos_next  = '0;
            crc_next  = CRC_INIT;
          end
        endcase
      end
      OP_LINK_ERR: begin
        hunt_next = WAIT_G;
        pos_next  = '0;
        crc_next  = CRC_INIT;
      end
      OP_POP: begin
        if (do_pop) begin
          head_next = ptr_inc(head);
          fill_next = fill - FW'(1);
          pv_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt      <= WAIT_G;
      pos       <= '0;
      crc       <= CRC_INIT;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        hunt <= hunt_next;
        pos  <= pos_next;
        crc  <= crc_next;
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq          <= seq_next;
      ptype        <= ptype_next;
      pvalue       <= pvalue_next;
      crc_lo       <= crc_lo_next;
      frame_status <= status_next;
      pop_valid    <= pv_next;
    end
  end

  // queue memory: a write at the tail or a registered read at the head, never both
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      queue_mem[tail] <= wr_pkt;
    end else if (accept && do_pop) begin
      rd_pkt <= queue_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{code_auto: 8'd0, code_manual_position: 8'd1, code_manual_rate: 8'd2,
               code_stop: 8'd3, code_home: 8'd4};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AUTO:        cfg.code_auto            <= cfg_data;
        CFG_MANUAL_POS:  cfg.code_manual_position <= cfg_data;
        CFG_MANUAL_RATE: cfg.code_manual_rate     <= cfg_data;
        CFG_STOP:        cfg.code_stop            <= cfg_data;
        CFG_HOME:        cfg.code_home            <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // fill always matches the item held in the output register
  assign queued_count = 3'(fill);
  assign popped_seq   = pop_valid ? rd_pkt.seq : '0;
  assign popped_type  = pop_valid ? rd_pkt.ptype : '0;
  assign popped_value = pop_valid ? signed'(rd_pkt.value) : '0;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == FW'(QUEUE_DEPTH)) |-> head == tail)
    else $error("queue pointers disagree with fill");

  a_pop_no_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop_valid) |-> frame_status == ST_NONE)
    else $error("pop result also reports a frame");

  a_collect_pos: assert property (@(posedge clk) disable iff (rst)
    hunt == COLLECT |-> (pos >= POS_FIRST_DATA && pos <= POS_LAST))
    else $error("byte position out of frame while collecting");
`endif

endmodule
`default_nettype wire
